### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

### rtl/core/tfbh_pkg.sv
package tfbh_pkg;

  localparam int unsigned COUNT_W = 20;

  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_APOS    = 8'h27;

  localparam logic [4:0] SYM_APOS  = 5'd26;
  localparam logic [4:0] SYM_SPACE = 5'd27;

  typedef enum logic [1:0] {
    REQ_TEXT   = 2'd0,
    REQ_SINGLE = 2'd1,
    REQ_PAIR   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] text_byte;
    logic [4:0] first_symbol;
    logic [4:0] second_symbol;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic               byte_kept;
    logic [4:0]         kept_symbol;
  } out_res_t;

  // What the stream filter decides for the byte on offer.
  typedef struct packed {
    logic       kept;
    logic [4:0] sym;
    logic       prev_valid;
    logic [4:0] prev_sym;
  } filt_dec_t;

  function automatic logic [4:0] map_byte(input logic [7:0] b);
    logic [4:0] sym;
    sym = SYM_SPACE;
    if (b >= 8'h61 && b <= 8'h7A) begin
      sym = 5'(b - 8'h61);
    end else if (b >= 8'h41 && b <= 8'h5A) begin
      sym = 5'(b - 8'h41);
    end else if (b == CHAR_APOS) begin
      sym = SYM_APOS;
    end
    return sym;
  endfunction

endpackage

### rtl/core/tfbh_filter.sv
module tfbh_filter
  import tfbh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  output filt_dec_t  dec_o
);

  logic       erasing_q, erasing_d;
  logic       nl_q, nl_d;
  logic       prev_valid_q, prev_valid_d;
  logic [4:0] prev_sym_q, prev_sym_d;

  logic       is_nl;
  logic [4:0] sym;
  logic       kept;

  assign is_nl = (byte_i == CHAR_NEWLINE);
  assign sym   = map_byte(byte_i);

  always_comb begin
    erasing_d = erasing_q;
    kept      = 1'b0;
    priority if (erasing_q) begin
      erasing_d = !is_nl;
    end else if (byte_i == CHAR_STAR && nl_q) begin
      erasing_d = 1'b1;
    end else begin
      // A space right after a kept space is folded into it.
      kept = !(sym == SYM_SPACE && prev_valid_q && prev_sym_q == SYM_SPACE);
    end
  end

  always_comb begin
    nl_d         = nl_q;
    prev_valid_d = prev_valid_q;
    prev_sym_d   = prev_sym_q;
    if (step_i) begin
      nl_d = is_nl;
      if (kept) begin
        prev_valid_d = 1'b1;
        prev_sym_d   = sym;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erasing_q    <= 1'b0;
      nl_q         <= 1'b1;
      prev_valid_q <= 1'b0;
      prev_sym_q   <= '0;
    end else if (clear_i) begin
      erasing_q    <= 1'b0;
      nl_q         <= 1'b1;
      prev_valid_q <= 1'b0;
      prev_sym_q   <= '0;
    end else begin
      if (step_i) begin
        erasing_q <= erasing_d;
      end
      nl_q         <= nl_d;
      prev_valid_q <= prev_valid_d;
      prev_sym_q   <= prev_sym_d;
    end
  end

  assign dec_o.kept       = kept;
  assign dec_o.sym        = sym;
  assign dec_o.prev_valid = prev_valid_q;
  assign dec_o.prev_sym   = prev_sym_q;

endmodule

### rtl/core/text_filter_bigram_histogram.sv
// Character bigram histogram over a filtered text stream.
//
// Requests enter on in_valid_i / in_stall_o / in_req_i and each gives exactly one
// result on out_valid_o / out_stall_i / out_res_o. A text byte is filtered (erased
// star lines, case folding, space collapsing) and, if kept, bumps the single count
// of its symbol and the pair count with the previous kept symbol; read requests
// return one count; a clear request zeroes both count stores and the stream state.
// One request is taken per cycle while in_stall_o is low. The count memories are
// read at the accepting edge, and when the read stage advances the saturating
// increment goes into the write back and the result into the output register.
// A write forwarding register per memory covers a request that reads the entry
// written by the one just ahead of it.
// Reset, and every clear request, starts a sweep over the SYMBOLS*SYMBOLS entries
// (784 by default) that zeroes the memories one entry a cycle; in_stall_o stays
// high for the whole sweep. While out_stall_i holds a result, the result stays put,
// one more request may enter the read stage, and in_stall_o rises after that.

`include "assert_macros.svh"

module text_filter_bigram_histogram
  import tfbh_pkg::*;
#(
  parameter int unsigned SYMBOLS    = 28,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_res_o
);

  localparam int unsigned SYM_AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned PAIR_DEPTH = SYMBOLS * SYMBOLS;
  localparam int unsigned PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int unsigned EXT_W      = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  typedef struct packed {
    req_e               kind;
    logic               s_wr;
    logic               p_wr;
    logic               rd_ok;
    logic [SYM_AW-1:0]  s_addr;
    logic [PAIR_AW-1:0] p_addr;
    logic               kept;
    logic [4:0]         ksym;
  } stage_t;

  state_e             state_q;
  logic [PAIR_AW-1:0] clr_idx_q;
  logic               clr_we;

  logic [COUNT_BITS-1:0] single_mem [SYMBOLS];
  logic [COUNT_BITS-1:0] pair_mem [PAIR_DEPTH];
  logic [COUNT_BITS-1:0] s_rd_q, p_rd_q;

  stage_t s1_q, cap;
  logic   s1_valid_q;
  logic   s1_adv;
  logic   in_acc;
  req_e   req;

  filt_dec_t dec;
  logic [4:0] s_sel, a_sel, b_sel;

  logic                  fs_v_q, fp_v_q;
  logic [SYM_AW-1:0]     fs_addr_q;
  logic [PAIR_AW-1:0]    fp_addr_q;
  logic [COUNT_BITS-1:0] fs_data_q, fp_data_q;
  logic [COUNT_BITS-1:0] s_cur, p_cur, s_new, p_new;
  logic [EXT_W-1:0]      s_ext, p_ext;

  out_res_t res;
  out_res_t out_q;
  logic     out_valid_q;

  assign req    = req_e'(in_req_i.req_type);
  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != ST_RUN) || (s1_valid_q && !s1_adv);
  assign in_acc = in_valid_i && !in_stall_o;
  assign clr_we = (state_q == ST_CLEAR);

  tfbh_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc && req == REQ_TEXT),
    .clear_i(in_acc && req == REQ_CLEAR),
    .byte_i (in_req_i.text_byte),
    .dec_o  (dec)
  );

  // Request capture: decide the writes and the memory addresses to read.
  always_comb begin
    cap.kind  = req;
    cap.s_wr  = 1'b0;
    cap.p_wr  = 1'b0;
    cap.rd_ok = 1'b0;
    cap.kept  = 1'b0;
    cap.ksym  = '0;
    s_sel     = in_req_i.first_symbol;
    a_sel     = in_req_i.first_symbol;
    b_sel     = in_req_i.second_symbol;
    unique case (req)
      REQ_TEXT: begin
        cap.kept = dec.kept;
        cap.ksym = dec.kept ? dec.sym : 5'd0;
        cap.s_wr = dec.kept && (7'(dec.sym) < 7'(SYMBOLS));
        cap.p_wr = dec.kept && (7'(dec.sym) < 7'(SYMBOLS)) && dec.prev_valid &&
                   (7'(dec.prev_sym) < 7'(SYMBOLS));
        s_sel    = dec.sym;
        a_sel    = dec.prev_sym;
        b_sel    = dec.sym;
      end
      REQ_SINGLE: begin
        cap.rd_ok = 7'(in_req_i.first_symbol) < 7'(SYMBOLS);
      end
      REQ_PAIR: begin
        cap.rd_ok = (7'(in_req_i.first_symbol) < 7'(SYMBOLS)) &&
                    (7'(in_req_i.second_symbol) < 7'(SYMBOLS));
      end
      REQ_CLEAR: begin
        cap.rd_ok = 1'b0;
      end
    endcase
    cap.s_addr = SYM_AW'(s_sel);
    cap.p_addr = PAIR_AW'(13'(a_sel) * 13'(SYMBOLS) + 13'(b_sel));
  end

  // Synchronous reads, issued only when a request is taken.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_rd_q <= single_mem[cap.s_addr];
      p_rd_q <= pair_mem[cap.p_addr];
    end
  end

  // Write port: the clearing sweep, or the write back of the read stage.
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      pair_mem[clr_idx_q] <= '0;
      if ((PAIR_AW + 1)'(clr_idx_q) < (PAIR_AW + 1)'(SYMBOLS)) begin
        single_mem[SYM_AW'(clr_idx_q)] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_q.s_wr) begin
        single_mem[s1_q.s_addr] <= s_new;
      end
      if (s1_q.p_wr) begin
        pair_mem[s1_q.p_addr] <= p_new;
      end
    end
  end

  // The memory returns the old value when the entry was written at the edge of
  // the read, so the last written value is forwarded on an address match.
  assign s_cur = (fs_v_q && fs_addr_q == s1_q.s_addr) ? fs_data_q : s_rd_q;
  assign p_cur = (fp_v_q && fp_addr_q == s1_q.p_addr) ? fp_data_q : p_rd_q;
  assign s_new = (s_cur == CNT_MAX) ? s_cur : s_cur + 1'b1;
  assign p_new = (p_cur == CNT_MAX) ? p_cur : p_cur + 1'b1;
  assign s_ext = EXT_W'(s_cur);
  assign p_ext = EXT_W'(p_cur);

  always_comb begin
    res.count_value = '0;
    if (s1_q.rd_ok && s1_q.kind == REQ_SINGLE) begin
      res.count_value = s_ext[COUNT_W-1:0];
    end else if (s1_q.rd_ok && s1_q.kind == REQ_PAIR) begin
      res.count_value = p_ext[COUNT_W-1:0];
    end
    res.byte_kept   = s1_q.kept;
    res.kept_symbol = s1_q.ksym;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_v_q <= 1'b0;
      fp_v_q <= 1'b0;
    end else if (clr_we) begin
      fs_v_q <= 1'b0;
      fp_v_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_q.s_wr) begin
        fs_v_q <= 1'b1;
      end
      if (s1_q.p_wr) begin
        fp_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.s_wr) begin
      fs_addr_q <= s1_q.s_addr;
      fs_data_q <= s_new;
    end
    if (s1_adv && s1_q.p_wr) begin
      fp_addr_q <= s1_q.p_addr;
      fp_data_q <= p_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_idx_q == PAIR_AW'(PAIR_DEPTH - 1)) begin
            state_q <= ST_RUN;
          end
          clr_idx_q <= clr_idx_q + 1'b1;
        end
        ST_RUN: begin
          if (in_acc && req == REQ_CLEAR) begin
            state_q   <= ST_CLEAR;
            clr_idx_q <= '0;
          end
        end
        default: begin
          state_q   <= ST_CLEAR;
          clr_idx_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= cap;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `ASSERT_NEVER(a_sweep_write_clash, clk_i, rst_ni, clr_we && s1_adv && (s1_q.s_wr || s1_q.p_wr), "count write back collides with the clearing sweep")
  `ASSERT_HOLDS(a_clear_starts_sweep, clk_i, rst_ni, (in_acc && req == REQ_CLEAR) |=> (state_q == ST_CLEAR && clr_idx_q == '0), "clear request did not start the sweep")
  `ASSERT_HOLDS(a_kept_has_no_count, clk_i, rst_ni, (out_valid_q && out_q.byte_kept) |-> (out_q.count_value == '0), "text result carries a count")

endmodule
